// ===== hw/rtl/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg
// Types, constants and helpers shared by the dual piecewise-linear shaper.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int MaxPointsDef = 64;
  localparam int FracBits     = 12;
  localparam int QueueDepth   = 4;
  localparam int InDataW      = 72;
  localparam int OutDataW     = 40;
  localparam int CfgAddrW     = 2;
  localparam int CfgDataW     = 16;
  localparam int SatW         = 56;
  localparam int DivSteps     = 34;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_POINT_COUNT  = 2'd0,
    CFG_INPUT_OFFSET = 2'd1,
    CFG_INPUT_GAIN   = 2'd2,
    CFG_OUTPUT_SCALE = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ABOVE = 2'd1,
    STAT_ZERO  = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef struct packed {
    logic               [6:0]  point_count;
    logic signed        [15:0] input_offset;
    logic               [15:0] input_gain;
    logic               [15:0] output_scale;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic        [5:0]  point_index;
    logic signed [15:0] point_level;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] level;
  } entry_t;

  // queue to back end: item on offer, back end takes it
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

  // returns {saturated, value}
  function automatic logic [16:0] sat16(input logic signed [SatW-1:0] v);
    logic [16:0] r;
    if (v > SatW'(32767)) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -SatW'(32768)) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dps_ram.sv =====
// ----------------------------------------------------------------------------
// dps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dps_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dps_front.sv =====
// ----------------------------------------------------------------------------
// dps_front
// Accepts items, classifies them, drops out-of-range writes, queues the rest.
// ----------------------------------------------------------------------------
module dps_front #(
  parameter int MAX_POINTS = dps_pkg::MaxPointsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dps_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        pop_i,
  output dps_pkg::q_out_t             q_o
);
  import dps_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  item_t            in_item;
  logic             keep, push, pop;

  always_comb begin
    in_item.kind        = kind_e'(s_axis_tuser);
    in_item.point_index = s_axis_tdata[5:0];
    in_item.point_level = s_axis_tdata[21:6];
    in_item.point_x     = s_axis_tdata[37:22];
    in_item.point_y     = s_axis_tdata[53:38];
    in_item.sample      = s_axis_tdata[69:54];
  end

  assign keep          = (in_item.kind == KIND_SAMPLE) ||
                         (int'(in_item.point_index) < MAX_POINTS);
  assign s_axis_tready = (count_q != (PtrW+1)'(QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign pop           = pop_i && (count_q != '0);

  assign wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign count_d  = count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  assign q_o.valid = (count_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == (PtrW+1)'(QueueDepth) |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !q_o.valid |=> count_q == $past(count_q) + (PtrW+1)'($past(push)))
    else $error("queue pop while empty changed count");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow push");

endmodule

// ===== hw/rtl/dps_back.sv =====
// ----------------------------------------------------------------------------
// dps_back
// Executes queued items: table writes, segment search, serial divide,
// scaling, saturation and the result register.
// ----------------------------------------------------------------------------
module dps_back #(
  parameter int MAX_POINTS = dps_pkg::MaxPointsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dps_pkg::cfg_t                cfg_i,
  input  dps_pkg::q_out_t              q_i,
  output logic                         pop_o,
  output logic                         ram_we_o,
  output logic [$clog2(MAX_POINTS)-1:0] ram_waddr_o,
  output dps_pkg::entry_t              ram_wdata_o,
  output logic [$clog2(MAX_POINTS)-1:0] ram_raddr_o,
  input  dps_pkg::entry_t              ram_rdata_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dps_pkg::OutDataW-1:0] m_axis_tdata
);
  import dps_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1) > 7 ? $clog2(MAX_POINTS + 1) : 7;
  localparam int StepW = $clog2(DivSteps + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_NORM  = 10'b0000000010,
    ST_START = 10'b0000000100,
    ST_STEP  = 10'b0000001000,
    ST_PROD  = 10'b0000010000,
    ST_DIV   = 10'b0000100000,
    ST_ADD   = 10'b0001000000,
    ST_SCALE = 10'b0010000000,
    ST_SAT   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        seg_q, seg_d, cur_q, cur_d, last;
  logic [StepW-1:0]       cnt_q, cnt_d;
  logic                   ch_q, ch_d, mvalid_q, mvalid_d;
  logic signed [15:0]     smp_q, smp_d, norm_q, norm_d, xo_q, xo_d, yo_q, yo_d;
  logic                   nsat_q, nsat_d, osat_q, osat_d, neg_q, neg_d;
  entry_t                 a_q, a_d, b_q, b_d;
  logic [33:0]            dvd_q, dvd_d;
  logic [16:0]            div_q, div_d, rem_q, rem_d;
  logic signed [34:0]     iv_q, iv_d;
  logic signed [51:0]     sp_q, sp_d;
  logic [OutDataW-1:0]    mdata_q, mdata_d;
  logic [CntW-1:0]        pc_ext, n_clamp;

  logic signed [16:0]     sum17, dl, dout, w;
  logic signed [33:0]     prodn, num;
  logic signed [15:0]     o0, o1;
  logic [16:0]            nres, ores;
  logic [17:0]            remsh;
  logic signed [34:0]     sq;
  status_e                stat;

  assign pc_ext  = CntW'(cfg_i.point_count);
  assign n_clamp = (pc_ext < CntW'(2)) ? CntW'(2) :
                   (pc_ext > CntW'(MAX_POINTS)) ? CntW'(MAX_POINTS) : pc_ext;
  assign last    = IdxW'(n_clamp - CntW'(2));

  assign sum17 = 17'(smp_q) + 17'(cfg_i.input_offset);
  assign prodn = sum17 * $signed({1'b0, cfg_i.input_gain});
  assign nres  = sat16(SatW'(prodn >>> FracBits));
  assign o0    = ch_q ? a_q.y : a_q.x;
  assign o1    = ch_q ? b_q.y : b_q.x;
  assign dl    = 17'(norm_q) - 17'(a_q.level);
  assign dout  = 17'(o1) - 17'(o0);
  assign num   = dl * dout;
  assign w     = 17'(b_q.level) - 17'(a_q.level);
  assign remsh = {rem_q, dvd_q[33]};
  assign sq    = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign ores  = sat16(SatW'(sp_q >>> FracBits));

  always_comb begin
    if (b_q.level < norm_q) begin
      stat = STAT_ABOVE;
    end else if (a_q.level == b_q.level) begin
      stat = STAT_ZERO;
    end else if (osat_q) begin
      stat = STAT_SAT;
    end else begin
      stat = STAT_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    ch_d        = ch_q;
    mvalid_d    = mvalid_q && !m_axis_tready;
    smp_d       = smp_q;
    norm_d      = norm_q;
    nsat_d      = nsat_q;
    osat_d      = osat_q;
    neg_d       = neg_q;
    xo_d        = xo_q;
    yo_d        = yo_q;
    a_d         = a_q;
    b_d         = b_q;
    dvd_d       = dvd_q;
    div_d       = div_q;
    rem_d       = rem_q;
    iv_d        = iv_q;
    sp_d        = sp_q;
    mdata_d     = mdata_q;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = IdxW'(q_i.item.point_index);
    ram_wdata_o = '{y: q_i.item.point_y, x: q_i.item.point_x, level: q_i.item.point_level};
    ram_raddr_o = cur_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          if (q_i.item.kind == KIND_WRITE) begin
            ram_we_o = 1'b1;
          end else begin
            smp_d   = q_i.item.sample;
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        norm_d      = nres[15:0];
        nsat_d      = nres[16];
        cur_d       = (seg_q > last) ? '0 : seg_q;
        ram_raddr_o = cur_d;
        state_d     = ST_START;
      end
      ST_START: begin
        if (norm_q < ram_rdata_i.level && cur_q != '0) begin
          cur_d       = '0;
          ram_raddr_o = '0;
        end else begin
          a_d         = ram_rdata_i;
          ram_raddr_o = cur_q + 1'b1;
          state_d     = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cur_q < last && ram_rdata_i.level < norm_q) begin
          a_d         = ram_rdata_i;
          cur_d       = cur_q + 1'b1;
          ram_raddr_o = cur_q + IdxW'(2);
        end else begin
          b_d     = ram_rdata_i;
          seg_d   = cur_q;
          ch_d    = 1'b0;
          osat_d  = nsat_q;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        neg_d = num[33] ^ w[16];
        dvd_d = num[33] ? 34'(-num) : 34'(num);
        div_d = w[16] ? 17'(-w) : 17'(w);
        rem_d = '0;
        cnt_d = StepW'(DivSteps);
        if (w == '0) begin
          iv_d    = 35'(o0);
          state_d = ST_SCALE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (remsh >= {1'b0, div_q}) begin
          rem_d = 17'(remsh - {1'b0, div_q});
          dvd_d = {dvd_q[32:0], 1'b1};
        end else begin
          rem_d = remsh[16:0];
          dvd_d = {dvd_q[32:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        iv_d    = 35'(o0) + sq;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        sp_d    = iv_q * $signed({1'b0, cfg_i.output_scale});
        state_d = ST_SAT;
      end
      ST_SAT: begin
        osat_d = osat_q | ores[16];
        if (!ch_q) begin
          xo_d    = ores[15:0];
          ch_d    = 1'b1;
          state_d = ST_PROD;
        end else begin
          yo_d    = ores[15:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {6'd0, stat, yo_q, xo_q};
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seg_q    <= '0;
      cur_q    <= '0;
      cnt_q    <= '0;
      ch_q     <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seg_q    <= seg_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      ch_q     <= ch_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    norm_q  <= norm_d;
    nsat_q  <= nsat_d;
    osat_q  <= osat_d;
    neg_q   <= neg_d;
    xo_q    <= xo_d;
    yo_q    <= yo_d;
    a_q     <= a_d;
    b_q     <= b_d;
    dvd_q   <= dvd_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    iv_q    <= iv_d;
    sp_q    <= sp_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  a_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> state_q == ST_IDLE)
    else $error("table write outside idle");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q != '0)
    else $error("divider ran past its step count");
  a_above_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROD && b_q.level < norm_q |-> cur_q == last)
    else $error("search stopped early below a later point");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && mvalid_q && !m_axis_tready |=> state_q == ST_OUT)
    else $error("result overwrote a pending item");

endmodule

// ===== hw/rtl/dual_piecewise_linear_shaper.sv =====
// Sample items: the segment search starts at the kept segment, or at the first segment
// when it restarts, and steps over at most (clamped point_count) - 2 segments. The 34-step
// serial divider runs once for X and once for Y; a zero-width segment skips both divides.
// Write items are done in the back end's idle state; items queue four deep in front.
// Reset: registers to defaults, kept segment zero, table undefined until written.
// ----------------------------------------------------------------------------
// dual_piecewise_linear_shaper
// Piecewise-linear X/Y waveshaper with breakpoint table and serial divider.
// ----------------------------------------------------------------------------
module dual_piecewise_linear_shaper #(
  parameter int MAX_POINTS = dps_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dps_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [dps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_index, point_level, point_x, point_y, sample
  input  logic [dps_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // x_out, y_out, status
  output logic [dps_pkg::OutDataW-1:0]  m_axis_tdata
);
  import dps_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);

  cfg_t            cfg_q;
  q_out_t          q;
  logic            pop;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count  <= 7'd2;
      cfg_q.input_offset <= '0;
      cfg_q.input_gain   <= 16'd4096;
      cfg_q.output_scale <= 16'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_POINT_COUNT:  cfg_q.point_count  <= cfg_wdata_i[6:0];
        CFG_INPUT_OFFSET: cfg_q.input_offset <= cfg_wdata_i;
        CFG_INPUT_GAIN:   cfg_q.input_gain   <= cfg_wdata_i;
        CFG_OUTPUT_SCALE: cfg_q.output_scale <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .pop_i (pop),
    .q_o   (q)
  );

  dps_ram #(.Width($bits(entry_t)), .Depth(MAX_POINTS)) u_table (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dps_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .q_i         (q),
    .pop_o       (pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams breakpoint writes and samples through the shaper under several
// register settings and checks every shaped X/Y/status item against an
// in-bench fixed-point predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import dps_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    status_e            status;
  } shaped_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  dual_piecewise_linear_shaper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shaper mirror
  logic signed [15:0] lvl_tbl [MaxPointsDef];
  logic signed [15:0] x_tbl   [MaxPointsDef];
  logic signed [15:0] y_tbl   [MaxPointsDef];
  int unsigned        kept_seg = 0;
  logic [6:0]         n_points = 7'd2;
  logic signed [15:0] in_offset = 16'sd0;
  logic [15:0]        in_gain = 16'd4096;
  logic [15:0]        out_scale = 16'd4096;

  item_t   pend_items [$];
  shaped_t shaped_q [$];
  int      errors = 0;
  int      n_samples = 0;
  int      n_shaped = 0;
  int      n_phases = 0;
  int      status_seen [4] = '{0, 0, 0, 0};

  function automatic longint clip16(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint lerp(input longint s, input longint l0, input longint l1,
                                  input longint o0, input longint o1);
    if (l1 == l0) return o0;
    return o0 + ((s - l0) * (o1 - o0)) / (l1 - l0);
  endfunction

  function automatic shaped_t shape_sample(input logic signed [15:0] smp);
    shaped_t     r;
    bit          sat;
    int unsigned cnt, last, seg;
    longint      norm, xi, yi;
    sat = 1'b0;
    cnt = n_points;
    if (cnt < 2) cnt = 2;
    if (cnt > MaxPointsDef) cnt = MaxPointsDef;
    last = cnt - 2;
    norm = clip16(((longint'(smp) + longint'(in_offset)) * longint'(in_gain)) >>> FracBits,
                  sat);
    seg = kept_seg;
    if (seg > last || norm < lvl_tbl[seg]) seg = 0;
    while (seg < last && lvl_tbl[seg+1] < norm) seg++;
    kept_seg = seg;
    xi = lerp(norm, lvl_tbl[seg], lvl_tbl[seg+1], x_tbl[seg], x_tbl[seg+1]);
    yi = lerp(norm, lvl_tbl[seg], lvl_tbl[seg+1], y_tbl[seg], y_tbl[seg+1]);
    r.x = 16'(clip16((xi * longint'(out_scale)) >>> FracBits, sat));
    r.y = 16'(clip16((yi * longint'(out_scale)) >>> FracBits, sat));
    if (lvl_tbl[seg+1] < norm) r.status = STAT_ABOVE;
    else if (lvl_tbl[seg] == lvl_tbl[seg+1]) r.status = STAT_ZERO;
    else if (sat) r.status = STAT_SAT;
    else r.status = STAT_OK;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // driver
  int s_gap = 0;
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_WRITE) begin
          lvl_tbl[s_tdata[5:0]] <= s_tdata[21:6];
          x_tbl[s_tdata[5:0]]   <= s_tdata[37:22];
          y_tbl[s_tdata[5:0]]   <= s_tdata[53:38];
        end else begin
          shaped_q.push_back(shape_sample(s_tdata[69:54]));
          n_samples++;
        end
        s_gap = gap_len();
      end
      if (!s_tvalid || s_tready) begin
        if (s_gap > 0 || pend_items.size() == 0) begin
          if (s_gap > 0) s_gap--;
          s_tvalid <= 1'b0;
        end else begin
          it = pend_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.kind;
          s_tdata  <= {2'b00, it.sample, it.point_y, it.point_x, it.point_level,
                       it.point_index};
        end
      end
    end
  end

  // monitor
  int m_gap = 0;
  always @(posedge clk_i) begin
    shaped_t e;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        n_shaped++;
        if (shaped_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item %h", m_tdata);
        end else begin
          e = shaped_q.pop_front();
          status_seen[e.status]++;
          if (m_tdata[15:0] !== e.x || m_tdata[31:16] !== e.y ||
              m_tdata[33:32] !== e.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
                       e.x, e.y, e.status, $signed(m_tdata[15:0]),
                       $signed(m_tdata[31:16]), m_tdata[33:32]);
          end
        end
        m_gap = gap_len();
      end
      if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put_write(input int idx, input int lvl, input int xv, input int yv);
    item_t it;
    it = '0;
    it.kind = KIND_WRITE;
    it.point_index = 6'(idx);
    it.point_level = 16'(lvl);
    it.point_x = 16'(xv);
    it.point_y = 16'(yv);
    it.sample = 16'($urandom);
    pend_items.push_back(it);
  endtask

  task automatic put_sample(input int smp);
    item_t it;
    it = '0;
    it.kind = KIND_SAMPLE;
    it.point_index = 6'($urandom);
    it.point_level = 16'($urandom);
    it.point_x = 16'($urandom);
    it.point_y = 16'($urandom);
    it.sample = 16'(smp);
    pend_items.push_back(it);
  endtask

  task automatic drain();
    while (pend_items.size() != 0 || s_tvalid || shaped_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e addr, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    case (addr)
      CFG_POINT_COUNT:  n_points = data[6:0];
      CFG_INPUT_OFFSET: in_offset = data;
      CFG_INPUT_GAIN:   in_gain = data;
      default:          out_scale = data;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic int rnd16();
    int p;
    p = $urandom_range(9);
    if (p == 0) return -32768;
    if (p == 1) return 32767;
    return $signed(16'($urandom));
  endfunction

  // ascending table with random content, occasional flat segments
  task automatic load_table(input int cnt);
    int lvl, stp;
    lvl = $urandom_range(3) == 0 ? -32768 : -$urandom_range(32768, 8000);
    stp = 65536 / cnt;
    for (int i = 0; i < cnt; i++) begin
      put_write(i, lvl, rnd16(), rnd16());
      if ($urandom_range(7) != 0) lvl += $urandom_range(stp, 1);
      if (lvl > 32767) lvl = 32767;
    end
  endtask

  initial begin
    int cnt;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fill the whole table so no unwritten entry is ever read
    for (int i = 0; i < MaxPointsDef; i++)
      put_write(i, -32768 + i * 1024, i * 500 - 16000, 16000 - i * 500);
    // directed: reset settings, two points
    put_write(0, -4096, -8192, 4096);
    put_write(1, 4096, 8192, -4096);
    put_sample(-32768); put_sample(32767); put_sample(0); put_sample(-4096);
    put_sample(4096); put_sample(-8000); put_sample(8000);
    put_write(1, -4096, 32767, -32768);
    put_sample(-4096); put_sample(100);
    put_write(1, 4096, 32767, -32768);
    put_sample(4000); put_sample(-30000);
    drain();
    n_phases++;
    // extremes of every register
    cfg_write(CFG_POINT_COUNT, 16'd64);
    cfg_write(CFG_INPUT_OFFSET, 16'h8000);
    cfg_write(CFG_INPUT_GAIN, 16'hFFFF);
    cfg_write(CFG_OUTPUT_SCALE, 16'hFFFF);
    put_sample(-32768); put_sample(32767); put_sample(0); put_sample(16384);
    put_sample(-1);
    drain();
    cfg_write(CFG_INPUT_OFFSET, 16'h7FFF);
    cfg_write(CFG_INPUT_GAIN, 16'h0000);
    cfg_write(CFG_OUTPUT_SCALE, 16'h0000);
    cfg_write(CFG_POINT_COUNT, 16'd0);
    put_sample(123); put_sample(-32768);
    drain();
    cfg_write(CFG_POINT_COUNT, 16'd127);
    cfg_write(CFG_INPUT_GAIN, 16'd4096);
    cfg_write(CFG_OUTPUT_SCALE, 16'd4096);
    cfg_write(CFG_INPUT_OFFSET, 16'd0);
    put_sample(32767); put_sample(-32768); put_sample(5);
    drain();
    n_phases++;
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(5))
        0: cnt = $urandom_range(1, 0);
        1: cnt = 64;
        2: cnt = $urandom_range(127, 65);
        default: cnt = $urandom_range(12, 2);
      endcase
      cfg_write(CFG_POINT_COUNT, 16'(cnt));
      cfg_write(CFG_INPUT_OFFSET, $urandom_range(2) == 0 ? 16'($urandom) :
                16'($urandom_range(1024)));
      cfg_write(CFG_INPUT_GAIN, $urandom_range(2) == 0 ? 16'($urandom) :
                16'($urandom_range(8192, 2048)));
      cfg_write(CFG_OUTPUT_SCALE, $urandom_range(2) == 0 ? 16'($urandom) :
                16'($urandom_range(8192, 2048)));
      if (cnt < 2) cnt = 2;
      if (cnt > 64) cnt = 64;
      load_table(cnt);
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(19) == 0) begin
          // noise: writes mostly outside the active range, else inside it (always inside with 64 points)
          if (cnt < 64 && $urandom_range(3) != 0)
            put_write($urandom_range(63, cnt), rnd16(), rnd16(), rnd16());
          else
            put_write($urandom_range(cnt - 1), rnd16(), rnd16(), rnd16());
        end else begin
          put_sample(rnd16());
        end
      end
      drain();
      n_phases++;
    end
    $display("Covered %0d phases, %0d samples shaped, %0d items checked", n_phases,
             n_samples, n_shaped);
    $display("Status counts ok=%0d above=%0d zero=%0d sat=%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== dual_piecewise_linear_shaper.f =====
hw/rtl/dps_pkg.sv
hw/rtl/dps_ram.sv
hw/rtl/dps_front.sv
hw/rtl/dps_back.sv
hw/rtl/dual_piecewise_linear_shaper.sv
tb/tb_top.sv
